FILE: hdl/dphd_pkg.sv
// ----------------------------------------------------------------------------
// dphd_pkg
// Shared types and constants for the dual paddle debounce and hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dphd_pkg;

    // timestamp arithmetic width, differences wrap modulo 2**TIME_BITS
    localparam int TIME_BITS = 32;

    // field widths
    localparam int NOW_BITS = 32;
    localparam int CFG_BITS = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int IN_DATA_BITS = 40;
    localparam int OUT_DATA_BITS = 16;
    localparam int OUT_FIELD_BITS = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_MS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_MS = 2'd2;

    // configuration reset values
    localparam logic [CFG_BITS-1:0] DEBOUNCE_MS_RST = 16'd5;
    localparam logic [CFG_BITS-1:0] HOLD_MS_RST = 16'd10000;
    localparam logic [CFG_BITS-1:0] FLASH_MS_RST = 16'd50;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CFG_BITS-1:0] t_cfg;

    // one result request, left_down in the lowest bit
    typedef struct packed {
        logic combo_held;
        logic config_request;
        logic led_on;
        logic right_release;
        logic right_press;
        logic left_release;
        logic left_press;
        logic right_down;
        logic left_down;
    } t_result;

    // controls from the top level to one paddle debouncer
    typedef struct packed {
        logic en;
        logic raw;
    } t_dbc_ctl;

endpackage

`default_nettype wire

FILE: hdl/dphd_debounce.sv
// ----------------------------------------------------------------------------
// dphd_debounce
// Debouncer for one paddle: tracks the last raw level and when it changed,
// and takes a new stable level once the raw level has held long enough.
// ----------------------------------------------------------------------------
`default_nettype none

module dphd_debounce (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire dphd_pkg::t_dbc_ctl i_ctl,
    input  wire dphd_pkg::t_time  i_now,
    input  wire dphd_pkg::t_cfg   i_debounce_ms,
    output logic                  o_stable_next
);

    logic            r_last_raw;
    logic            r_stable;
    dphd_pkg::t_time r_stamp;

    logic            n_last_raw;
    logic            n_stable;
    dphd_pkg::t_time n_stamp;
    dphd_pkg::t_time w_elapsed;

    // restart the timer on a raw edge, then compare elapsed time
    always_comb begin
        n_last_raw = r_last_raw;
        n_stamp    = r_stamp;
        if (i_ctl.raw != r_last_raw) begin
            n_last_raw = i_ctl.raw;
            n_stamp    = i_now;
        end
        w_elapsed = i_now - n_stamp;
        if (w_elapsed >= dphd_pkg::t_time'(i_debounce_ms)) begin
            n_stable = i_ctl.raw;
        end else begin
            n_stable = r_stable;
        end
    end

    assign o_stable_next = n_stable;

    // state registers, advanced once per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= 1'b1;
            r_stable   <= 1'b1;
            r_stamp    <= '0;
        end else if (i_ctl.en) begin
            r_last_raw <= n_last_raw;
            r_stable   <= n_stable;
            r_stamp    <= n_stamp;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dual_paddle_debounce_hold_detect_top.sv
// ----------------------------------------------------------------------------
// dual_paddle_debounce_hold_detect_top
// Two-paddle debouncer with press/release events, indicator pulse and a
// both-held configuration request.
// ----------------------------------------------------------------------------
// channel   | direction | contents
// s_axis    | in        | tdata: now_ms[31:0], raw_left[32], raw_right[33]
// m_axis    | out       | tdata: left_down .. combo_held in bits [8:0]
// cfg       | in        | index 0 debounce_ms, 1 hold_ms, 2 flash_ms
//
// one sample per cycle while the result is not stalled; a sample passes the
// input register, then one pass of compare/subtract logic into the result
// register. the input side keeps accepting while the result register is
// full as long as it is being taken; a stalled result holds both stages.
// reset clears all key, timer and indicator state and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_paddle_debounce_hold_detect_top (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    // fields from bit 0: now_ms[31:0], raw_left, raw_right, zero fill
    input  wire [dphd_pkg::IN_DATA_BITS-1:0]           i_s_axis_tdata,
    input  wire                                        i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // fields from bit 0: left_down, right_down, left_press, left_release,
    // right_press, right_release, led_on, config_request, combo_held, zero fill
    output logic [dphd_pkg::OUT_DATA_BITS-1:0]         o_m_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  wire                                        i_m_axis_tready,
    input  wire                                        i_cfg_we,
    input  wire [dphd_pkg::CFG_IDX_BITS-1:0]           i_cfg_idx,
    input  wire [dphd_pkg::CFG_BITS-1:0]               i_cfg_wdata
);

    // configuration
    dphd_pkg::t_cfg r_debounce_ms;
    dphd_pkg::t_cfg r_hold_ms;
    dphd_pkg::t_cfg r_flash_ms;

    // input stage
    logic                          r_in_valid;
    logic [dphd_pkg::NOW_BITS-1:0] r_in_now;
    logic                          r_in_raw_l;
    logic                          r_in_raw_r;

    // sample state
    logic [1:0]      r_key_down;
    logic            r_led_active;
    dphd_pkg::t_time r_led_start;
    logic            r_combo_active;
    dphd_pkg::t_time r_combo_start;

    // result stage
    logic              r_out_valid;
    dphd_pkg::t_result r_out;

    // next values
    logic [1:0]        n_key_down;
    logic              n_led_active;
    dphd_pkg::t_time   n_led_start;
    logic              n_combo_active;
    dphd_pkg::t_time   n_combo_start;
    dphd_pkg::t_result n_out;

    logic               w_advance;
    logic               w_step;
    dphd_pkg::t_time    w_now;
    logic [1:0]         w_stable;
    logic [1:0]         w_press;
    logic [1:0]         w_release;
    logic               w_request;
    dphd_pkg::t_dbc_ctl w_ctl_l;
    dphd_pkg::t_dbc_ctl w_ctl_r;

    // pipeline flow
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_advance;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_now           = dphd_pkg::t_time'(r_in_now);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= dphd_pkg::DEBOUNCE_MS_RST;
            r_hold_ms     <= dphd_pkg::HOLD_MS_RST;
            r_flash_ms    <= dphd_pkg::FLASH_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dphd_pkg::CFG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_wdata;
                dphd_pkg::CFG_HOLD_MS:     r_hold_ms     <= i_cfg_wdata;
                dphd_pkg::CFG_FLASH_MS:    r_flash_ms    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_now   <= i_s_axis_tdata[dphd_pkg::NOW_BITS-1:0];
            r_in_raw_l <= i_s_axis_tdata[dphd_pkg::NOW_BITS];
            r_in_raw_r <= i_s_axis_tdata[dphd_pkg::NOW_BITS+1];
        end
    end

    // per-paddle debouncers
    assign w_ctl_l = '{en: w_step, raw: r_in_raw_l};
    assign w_ctl_r = '{en: w_step, raw: r_in_raw_r};

    dphd_debounce u_dbc_left (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl_l),
        .i_now         (w_now),
        .i_debounce_ms (r_debounce_ms),
        .o_stable_next (w_stable[0])
    );

    dphd_debounce u_dbc_right (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl_r),
        .i_now         (w_now),
        .i_debounce_ms (r_debounce_ms),
        .o_stable_next (w_stable[1])
    );

    // indicator timeout, hold detection and key events
    always_comb begin
        n_led_active   = r_led_active;
        n_led_start    = r_led_start;
        n_combo_active = r_combo_active;
        n_combo_start  = r_combo_start;
        n_key_down     = r_key_down;
        w_press        = 2'b00;
        w_release      = 2'b00;
        w_request      = 1'b0;

        if (r_led_active &&
            (w_now - r_led_start) >= dphd_pkg::t_time'(r_flash_ms)) begin
            n_led_active = 1'b0;
        end

        // both paddles pressed: first sample starts the hold timer
        if (!w_stable[0] && !w_stable[1]) begin
            if (!r_combo_active) begin
                n_combo_active = 1'b1;
                n_combo_start  = w_now;
            end else if ((w_now - r_combo_start) >= dphd_pkg::t_time'(r_hold_ms)) begin
                w_request = 1'b1;
            end
        end else begin
            n_combo_active = 1'b0;
            n_combo_start  = '0;
        end

        for (int k = 0; k < 2; k++) begin
            if (w_request) begin
                if (r_key_down[k]) begin
                    n_key_down[k] = 1'b0;
                    w_release[k]  = 1'b1;
                end
            end else if (!w_stable[k] && !r_key_down[k]) begin
                n_key_down[k] = 1'b1;
                w_press[k]    = 1'b1;
                n_led_active  = 1'b1;
                n_led_start   = w_now;
            end else if (w_stable[k] && r_key_down[k]) begin
                n_key_down[k] = 1'b0;
                w_release[k]  = 1'b1;
            end
        end

        n_out.left_down      = n_key_down[0];
        n_out.right_down     = n_key_down[1];
        n_out.left_press     = w_press[0];
        n_out.left_release   = w_release[0];
        n_out.right_press    = w_press[1];
        n_out.right_release  = w_release[1];
        n_out.led_on         = n_led_active;
        n_out.config_request = w_request;
        n_out.combo_held     = n_combo_active;
    end

    // sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down     <= 2'b00;
            r_led_active   <= 1'b0;
            r_led_start    <= '0;
            r_combo_active <= 1'b0;
            r_combo_start  <= '0;
        end else if (w_step) begin
            r_key_down     <= n_key_down;
            r_led_active   <= n_led_active;
            r_led_start    <= n_led_start;
            r_combo_active <= n_combo_active;
            r_combo_start  <= n_combo_start;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        (dphd_pkg::OUT_DATA_BITS - dphd_pkg::OUT_FIELD_BITS)'(0), r_out};

    // a request only follows a sample that already started the hold timer
    a_request_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_request |-> r_combo_active)
        else $error("request without a running hold timer");

    // a request sample carries no press events
    a_request_no_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.config_request |-> !r_out.left_press && !r_out.right_press)
        else $error("press reported on a request sample");

    // the shown key state matches the tracked key state
    a_down_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.left_down == r_key_down[0] &&
                        r_out.right_down == r_key_down[1])
        else $error("result key state differs from tracked state");

    // a press always lights the indicator
    a_press_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.left_press || r_out.right_press) |-> r_out.led_on)
        else $error("press without indicator");

    // a stalled result holds its contents
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: sim/dual_paddle_debounce_hold_detect_top_tb.sv
// ----------------------------------------------------------------------------
// dual_paddle_debounce_hold_detect_top_tb
// Self-checking bench for the two-paddle debouncer: streams timestamped pin
// samples, predicts every result in the bench and compares each field of
// every result request, with random stalls on both sides and several register
// settings, including all-zero and all-ones times and timestamp wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_paddle_debounce_hold_detect_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_SAMPLES = 1650;
    localparam int IDLE_PCT = 22;
    localparam int SETTLE_CYCLES = 4;
    // index with no register behind it, writes are dropped
    localparam logic [dphd_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [dphd_pkg::IN_DATA_BITS-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dphd_pkg::OUT_DATA_BITS-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_we = 1'b0;
    logic [dphd_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
    dphd_pkg::t_cfg cfg_wdata = '0;

    // bench state
    dphd_pkg::t_result pending_results[$];
    bit stream_no_idle = 1'b0;
    int n_errors = 0;
    int n_checked = 0;
    int n_requests = 0;
    int n_presses = 0;
    int n_settings = 0;
    int cycle_count = 0;
    string field_name[dphd_pkg::OUT_FIELD_BITS] = '{"left_down", "right_down",
        "left_press", "left_release", "right_press", "right_release", "led_on",
        "config_request", "combo_held"};

    // predictor copy of registers and paddle state
    dphd_pkg::t_cfg debounce_cfg;
    dphd_pkg::t_cfg hold_cfg;
    dphd_pkg::t_cfg flash_cfg;
    logic [1:0] stable_lvl;
    logic [1:0] last_raw;
    dphd_pkg::t_time change_at[2];
    logic [1:0] key_dn;
    logic led_lit;
    dphd_pkg::t_time led_at;
    logic combo_on;
    dphd_pkg::t_time combo_at;

    dual_paddle_debounce_hold_detect_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("MISMATCH %s", msg);
    endtask

    // one sample pass of the debouncer, hold detector and indicator
    function automatic dphd_pkg::t_result predict_sample(input dphd_pkg::t_time now,
                                                         input logic [1:0] raw);
        dphd_pkg::t_result r;
        logic req;
        logic [1:0] press;
        logic [1:0] release_ev;
        r = '0;
        req = 1'b0;
        press = 2'b00;
        release_ev = 2'b00;
        // indicator pulse ends
        if (led_lit && (now - led_at) >= dphd_pkg::t_time'(flash_cfg))
            led_lit = 1'b0;
        // debounce each paddle
        for (int k = 0; k < 2; k++) begin
            if (raw[k] != last_raw[k]) begin
                last_raw[k] = raw[k];
                change_at[k] = now;
            end
            if ((now - change_at[k]) >= dphd_pkg::t_time'(debounce_cfg) &&
                raw[k] != stable_lvl[k])
                stable_lvl[k] = raw[k];
        end
        // both held, the first sample only starts the timer
        if (stable_lvl == 2'b00) begin
            if (!combo_on) begin
                combo_on = 1'b1;
                combo_at = now;
            end else if ((now - combo_at) >= dphd_pkg::t_time'(hold_cfg)) begin
                req = 1'b1;
            end
        end else begin
            combo_on = 1'b0;
            combo_at = '0;
        end
        // key events
        for (int k = 0; k < 2; k++) begin
            if (req) begin
                if (key_dn[k]) begin
                    key_dn[k] = 1'b0;
                    release_ev[k] = 1'b1;
                end
            end else if (!stable_lvl[k] && !key_dn[k]) begin
                key_dn[k] = 1'b1;
                press[k] = 1'b1;
                led_lit = 1'b1;
                led_at = now;
            end else if (stable_lvl[k] && key_dn[k]) begin
                key_dn[k] = 1'b0;
                release_ev[k] = 1'b1;
            end
        end
        r.left_down = key_dn[0];
        r.right_down = key_dn[1];
        r.left_press = press[0];
        r.left_release = release_ev[0];
        r.right_press = press[1];
        r.right_release = release_ev[1];
        r.led_on = led_lit;
        r.config_request = req;
        r.combo_held = combo_on;
        return r;
    endfunction

    // result side: random stalls and field-by-field compare
    always @(posedge i_clk) begin
        dphd_pkg::t_result got;
        dphd_pkg::t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = dphd_pkg::t_result'(m_tdata[dphd_pkg::OUT_FIELD_BITS-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                for (int b = 0; b < dphd_pkg::OUT_FIELD_BITS; b++)
                    if (got[b] !== want[b])
                        report_mismatch($sformatf("result %0d %s: got %b expected %b",
                            n_checked, field_name[b], got[b], want[b]));
                n_checked++;
                if (want.config_request)
                    n_requests++;
                if (want.left_press || want.right_press)
                    n_presses++;
            end
        end
        m_tready <= stream_no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // send one sample and queue its prediction once it is accepted
    task automatic send_sample(input dphd_pkg::t_time now, input logic raw_l,
                               input logic raw_r);
        s_tdata <= {{(dphd_pkg::IN_DATA_BITS - dphd_pkg::NOW_BITS - 2){1'b0}},
                    raw_r, raw_l, now};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_sample(now, {raw_r, raw_l}));
        // random gap before the next request
        if (!stream_no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    // stop the stream and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dphd_pkg::CFG_IDX_BITS-1:0] idx,
                             input dphd_pkg::t_cfg value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            dphd_pkg::CFG_DEBOUNCE_MS: debounce_cfg = value;
            dphd_pkg::CFG_HOLD_MS: hold_cfg = value;
            dphd_pkg::CFG_FLASH_MS: flash_cfg = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input dphd_pkg::t_cfg deb, input dphd_pkg::t_cfg hold,
                             input dphd_pkg::t_cfg flash);
        write_reg(dphd_pkg::CFG_DEBOUNCE_MS, deb);
        write_reg(dphd_pkg::CFG_HOLD_MS, hold);
        write_reg(dphd_pkg::CFG_FLASH_MS, flash);
        n_settings++;
    endtask

    task automatic apply_reset();
        debounce_cfg = dphd_pkg::DEBOUNCE_MS_RST;
        hold_cfg = dphd_pkg::HOLD_MS_RST;
        flash_cfg = dphd_pkg::FLASH_MS_RST;
        stable_lvl = 2'b11;
        last_raw = 2'b11;
        change_at[0] = '0;
        change_at[1] = '0;
        key_dn = 2'b00;
        led_lit = 1'b0;
        led_at = '0;
        combo_on = 1'b0;
        combo_at = '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_settings++;
    endtask

    // reset defaults: press both, request after the hold time, re-press on exit
    task automatic test_default_hold();
        send_sample(32'd100, 1'b1, 1'b1);
        send_sample(32'd100, 1'b0, 1'b0);
        send_sample(32'd105, 1'b0, 1'b0);
        send_sample(32'd10104, 1'b0, 1'b0);
        send_sample(32'd10105, 1'b0, 1'b0);
        send_sample(32'd10106, 1'b0, 1'b0);
        send_sample(32'd10110, 1'b1, 1'b0);
        send_sample(32'd10115, 1'b1, 1'b0);
        send_sample(32'd10120, 1'b1, 1'b1);
        send_sample(32'd10125, 1'b1, 1'b1);
        settle();
    endtask

    // zero times: every condition is met at once
    task automatic test_zero_times();
        write_all(16'd0, 16'd0, 16'd0);
        send_sample(32'd20, 1'b0, 1'b1);
        send_sample(32'd21, 1'b0, 1'b0);
        send_sample(32'd21, 1'b0, 1'b0);
        send_sample(32'd22, 1'b1, 1'b1);
        settle();
    endtask

    // all-ones times across the timestamp wrap, unused index ignored
    task automatic test_max_times_wrap();
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'h0000);
        send_sample(32'hFFFF_FFF0, 1'b0, 1'b0);
        send_sample(32'h0000_FFEF, 1'b0, 1'b0);
        send_sample(32'h0001_FFEE, 1'b0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_sample(32'h0000_0000, 1'b1, 1'b1);
        settle();
    endtask

    function automatic dphd_pkg::t_cfg pick_time(input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 17)
            return 16'hFFFF;
        if (r < 22)
            return dphd_pkg::t_cfg'($urandom);
        return dphd_pkg::t_cfg'($urandom_range(hi, 1));
    endfunction

    // random paddle activity: held presses with bounce, some noise and jumps
    task automatic test_random_paddles();
        dphd_pkg::t_time now;
        logic [1:0] target;
        logic [1:0] raw;
        int sent;
        int run_len;
        int step_max;
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            // first phase runs with no idling on either side
            stream_no_idle = (sent == 0);
            write_all(pick_time(8), pick_time(60), pick_time(30));
            now = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(300) : $urandom;
            target = 2'b11;
            run_len = $urandom_range(180, 60);
            if (run_len > RANDOM_SAMPLES - sent)
                run_len = RANDOM_SAMPLES - sent;
            step_max = $urandom_range(6, 1);
            for (int n = 0; n < run_len; n++) begin
                if ($urandom_range(99) < 3)
                    now = $urandom;
                else
                    now = now + $urandom_range(step_max);
                if ($urandom_range(99) < 4)
                    target = 2'b00;
                for (int k = 0; k < 2; k++)
                    if ($urandom_range(99) < 6)
                        target[k] = ~target[k];
                if ($urandom_range(99) < 8)
                    raw = 2'($urandom);
                else
                    raw = target ^ {($urandom_range(99) < 12), ($urandom_range(99) < 12)};
                send_sample(now, raw[0], raw[1]);
            end
            sent += run_len;
            settle();
        end
        stream_no_idle = 1'b0;
    endtask

    initial begin
        apply_reset();
        test_default_hold();
        test_zero_times();
        test_max_times_wrap();
        test_random_paddles();
        settle();
        $display("checked %0d results over %0d register settings", n_checked, n_settings);
        $display("saw %0d press samples and %0d config requests", n_presses, n_requests);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/dphd_pkg.sv
hdl/dphd_debounce.sv
hdl/dual_paddle_debounce_hold_detect_top.sv
sim/dual_paddle_debounce_hold_detect_top_tb.sv
